// ----- rtl/ccc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants of the cross-channel color correction block.
// ----------------------------------------------------------------------------
package ccc_pkg;

   localparam int PIXEL_W      = 8;
   localparam int SEL_W        = 4;
   localparam int VALUE_W      = 18;
   localparam int NUM_CURVES   = 9;
   localparam int NUM_CHANNELS = 3;
   localparam int MID_DEPTH    = 4;
   localparam int RSP_DEPTH    = 16;
   localparam int LANE_LAT     = 6;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // curve selects: primaries first, then cross curves in pairs per channel
   localparam logic [SEL_W-1:0] SEL_R    = 4'd0;
   localparam logic [SEL_W-1:0] SEL_GR   = 4'd3;
   localparam logic [SEL_W-1:0] SEL_LAST = 4'd8;

   typedef logic [1:0] chan_type;
   localparam chan_type CH_R = 2'd0;
   localparam chan_type CH_G = 2'd1;
   localparam chan_type CH_B = 2'd2;

   typedef logic [PIXEL_W-1:0]        pixel_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam pixel_type PIXEL_MAX = '1;

   // channel whose input byte addresses each curve
   localparam chan_type CURVE_SRC [NUM_CURVES] =
      '{CH_R, CH_G, CH_B, CH_G, CH_B, CH_R, CH_B, CH_R, CH_G};

   typedef struct packed {
      logic             is_write;
      logic [SEL_W-1:0] sel;
      pixel_type        index;
      value_type        value;
      pixel_type        red;
      pixel_type        green;
      pixel_type        blue;
   } cmd_type;

endpackage
`default_nettype wire

// ----- rtl/ccc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_front
// Accepts request words, drops ignored table writes, clamps pixel indices
// and queues the rest for the back end.
// ----------------------------------------------------------------------------
module ccc_front #(
   parameter int CURVE_DEPTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic                          command,
   input  wire ccc_pkg::pixel_type            in_red,
   input  wire ccc_pkg::pixel_type            in_green,
   input  wire ccc_pkg::pixel_type            in_blue,
   input  wire logic [ccc_pkg::SEL_W-1:0]     table_select,
   input  wire ccc_pkg::pixel_type            table_index,
   input  wire ccc_pkg::value_type            table_value,
   output logic                               mid_valid,
   output ccc_pkg::cmd_type                   mid_word,
   input  wire logic                          mid_pop
);
   import ccc_pkg::*;

   localparam int PTR_W = $clog2(MID_DEPTH);
   localparam int CNT_W = $clog2(MID_DEPTH + 1);

   cmd_type            queue_ff [MID_DEPTH];
   cmd_type            word_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               keep;
   logic               enq;
   logic               deq;

   function automatic pixel_type clamp_px(pixel_type p);
      pixel_type r;
      r = p;
      if (32'(p) >= CURVE_DEPTH) begin
         r = pixel_type'(CURVE_DEPTH - 1);
      end
      return r;
   endfunction

   always_comb begin
      word_in.is_write = (command == CMD_WRITE);
      word_in.sel      = table_select;
      word_in.index    = table_index;
      word_in.value    = table_value;
      word_in.red      = clamp_px(in_red);
      word_in.green    = clamp_px(in_green);
      word_in.blue     = clamp_px(in_blue);
      keep = (command == CMD_PIXEL) ||
             ((table_select <= SEL_LAST) && (32'(table_index) < CURVE_DEPTH));
   end

   assign full      = (count_ff == CNT_W'(MID_DEPTH));
   assign mid_valid = (count_ff != '0);
   assign mid_word  = queue_ff[rd_ptr_ff];
   assign enq       = push && !full && keep;
   assign deq       = mid_pop && mid_valid;

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(enq) - CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ccc_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_lane
// One channel's arithmetic: f + (ca + cb) * (1 - f)^2, scaled by 255,
// rounded and saturated. Six register stages.
// ----------------------------------------------------------------------------
module ccc_lane #(
   parameter int FRACTION_BITS = 14
) (
   input  wire logic               clock,
   input  wire ccc_pkg::value_type f,
   input  wire ccc_pkg::value_type ca,
   input  wire ccc_pkg::value_type cb,
   output ccc_pkg::pixel_type      result
);
   import ccc_pkg::*;

   localparam int F     = FRACTION_BITS;
   localparam int INT_W = (F > VALUE_W - 1) ? F : VALUE_W - 1;
   localparam int D_W   = INT_W + 2;
   localparam int D2_W  = 2 * D_W - 1;
   localparam int LO_W  = D2_W / 2;
   localparam int HI_W  = D2_W - LO_W;
   localparam int S_W   = VALUE_W + 1;
   localparam int PH_W  = S_W + HI_W + 1;
   localparam int PL_W  = S_W + LO_W + 1;
   localparam int T_W   = D2_W + S_W + 1;
   localparam int R_W   = 3 * F + 9;

   localparam logic signed [D_W-1:0] ONE  = D_W'(1) << F;
   localparam logic [R_W-1:0]        HALF = R_W'(1) << (3 * F - 1);

   logic signed [D_W-1:0]   d1_ff, d1_in;
   logic signed [S_W-1:0]   s1_ff, s1_in, s2_ff;
   value_type               f1_ff, f2_ff, f3_ff, f4_ff;
   logic signed [2*D_W-1:0] sq;
   logic [D2_W-1:0]         d2_ff, d2_in;
   logic signed [PH_W-1:0]  ph_ff, ph_in;
   logic signed [PL_W-1:0]  pl_ff, pl_in;
   logic signed [T_W-1:0]   bias_ff, bias_in;
   logic signed [T_W-1:0]   t_ff, t_in;
   logic [R_W-1:0]          u;
   logic [R_W-1:0]          rnd;
   pixel_type               result_ff, result_in;

   always_comb begin
      d1_in   = ONE - D_W'(f);
      s1_in   = S_W'(ca) + S_W'(cb);
      sq      = d1_ff * d1_ff;
      d2_in   = sq[D2_W-1:0];
      ph_in   = s2_ff * $signed({1'b0, d2_ff[D2_W-1:LO_W]});
      pl_in   = s2_ff * $signed({1'b0, d2_ff[LO_W-1:0]});
      bias_in = (T_W'(ph_ff) <<< LO_W) + T_W'(pl_ff);
      t_in    = (T_W'(f4_ff) <<< (2 * F)) + bias_ff;
      u       = R_W'(t_ff[3*F-1:0]);
      rnd     = (u << 8) - u + HALF;
      priority if (t_ff[T_W-1]) begin
         result_in = '0;
      end else if (|t_ff[T_W-2:3*F]) begin
         result_in = PIXEL_MAX;
      end else begin
         result_in = rnd[3*F+PIXEL_W-1:3*F];
      end
   end

   always_ff @(posedge clock) begin
      d1_ff     <= d1_in;
      s1_ff     <= s1_in;
      f1_ff     <= f;
      d2_ff     <= d2_in;
      s2_ff     <= s1_ff;
      f2_ff     <= f1_ff;
      ph_ff     <= ph_in;
      pl_ff     <= pl_in;
      f3_ff     <= f2_ff;
      bias_ff   <= bias_in;
      f4_ff     <= f3_ff;
      t_ff      <= t_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

// ----- rtl/ccc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_back
// Curve memories, issue with result credits, three channel lanes and the
// response queue.
// ----------------------------------------------------------------------------
module ccc_back #(
   parameter int CURVE_DEPTH   = 256,
   parameter int FRACTION_BITS = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             mid_valid,
   input  wire ccc_pkg::cmd_type mid_word,
   output logic                  mid_pop,
   output logic                  empty,
   input  wire logic             pop,
   output ccc_pkg::pixel_type    out_red,
   output ccc_pkg::pixel_type    out_green,
   output ccc_pkg::pixel_type    out_blue
);
   import ccc_pkg::*;

   localparam int ADDR_W = $clog2(CURVE_DEPTH);
   localparam int OCC_W  = $clog2(RSP_DEPTH + 1);
   localparam int RPTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      pixel_type red;
      pixel_type green;
      pixel_type blue;
   } rgb_type;

   logic                issue;
   logic                issue_px;
   logic [ADDR_W-1:0]   wr_addr;
   pixel_type           px [NUM_CHANNELS];
   value_type           rd_data [NUM_CURVES];
   pixel_type           lane_out [NUM_CHANNELS];
   logic [LANE_LAT:0]   vld_ff, vld_in;
   logic                fifo_wr;
   logic                rd_pop;
   rgb_type             fifo_ff [RSP_DEPTH];
   logic [RPTR_W-1:0]   wptr_ff, wptr_in;
   logic [RPTR_W-1:0]   rptr_ff, rptr_in;
   logic [OCC_W-1:0]    rcnt_ff, rcnt_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   function automatic logic [ADDR_W-1:0] to_addr(pixel_type p);
      logic [ADDR_W+PIXEL_W-1:0] w;
      w = {{ADDR_W{1'b0}}, p};
      return w[ADDR_W-1:0];
   endfunction

   assign issue    = mid_valid && (mid_word.is_write || (occ_ff < OCC_W'(RSP_DEPTH)));
   assign issue_px = issue && !mid_word.is_write;
   assign mid_pop  = issue;
   assign wr_addr  = to_addr(mid_word.index);
   assign px[CH_R] = mid_word.red;
   assign px[CH_G] = mid_word.green;
   assign px[CH_B] = mid_word.blue;

   for (genvar k = 0; k < NUM_CURVES; k++) begin : g_curve
      value_type curve_mem [CURVE_DEPTH];
      value_type rd_ff;

      always_ff @(posedge clock) begin
         if (issue && mid_word.is_write && (mid_word.sel == SEL_W'(k))) begin
            curve_mem[wr_addr] <= mid_word.value;
         end
         if (issue_px) begin
            rd_ff <= curve_mem[to_addr(px[CURVE_SRC[k]])];
         end
      end

      assign rd_data[k] = rd_ff;
   end

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
      ccc_lane #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_lane (
         .clock  (clock),
         .f      (rd_data[SEL_R + c]),
         .ca     (rd_data[SEL_GR + 2 * c]),
         .cb     (rd_data[SEL_GR + 2 * c + 1]),
         .result (lane_out[c])
      );
   end

   assign fifo_wr   = vld_ff[LANE_LAT];
   assign rd_pop    = pop && !empty;
   assign empty     = (rcnt_ff == '0);
   assign out_red   = fifo_ff[rptr_ff].red;
   assign out_green = fifo_ff[rptr_ff].green;
   assign out_blue  = fifo_ff[rptr_ff].blue;

   always_comb begin
      vld_in  = {vld_ff[LANE_LAT-1:0], issue_px};
      wptr_in = fifo_wr ? wptr_ff + RPTR_W'(1) : wptr_ff;
      rptr_in = rd_pop ? rptr_ff + RPTR_W'(1) : rptr_ff;
      rcnt_in = rcnt_ff + OCC_W'(fifo_wr) - OCC_W'(rd_pop);
      occ_in  = occ_ff + OCC_W'(issue_px) - OCC_W'(rd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         wptr_ff <= '0;
         rptr_ff <= '0;
         rcnt_ff <= '0;
         occ_ff  <= '0;
      end else begin
         vld_ff  <= vld_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         rcnt_ff <= rcnt_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_ff[wptr_ff] <= '{red:   lane_out[CH_R],
                               green: lane_out[CH_G],
                               blue:  lane_out[CH_B]};
      end
   end

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(RSP_DEPTH))
      else $error("result credits exceeded");

   a_occ_cover: assert property (@(posedge clock) disable iff (reset)
      occ_ff >= rcnt_ff)
      else $error("queued results not covered by credits");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_wr |-> (rcnt_ff != OCC_W'(RSP_DEPTH)))
      else $error("response queue overflow");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      issue_px |-> ##(LANE_LAT + 1) fifo_wr)
      else $error("pixel lost in lanes");
`endif

endmodule
`default_nettype wire

// ----- rtl/cross_channel_color_correction.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cross_channel_color_correction
// Per-pixel RGB correction through three primary and six cross-channel
// curves loaded by table-write words.
//
//   channel   ports                                   handshake
//   request   req_command .. req_table_value          push / full
//   response  rsp_out_red, rsp_out_green, rsp_out_blue  empty / pop
//
// One word per cycle sustained while full stays low; a pixel passes through the
// front queue, the curve read, six lane stages and the response queue.
// Table writes occupy one issue slot and give no response.
// Reset clears queue and pipeline control; curve entries hold garbage
// until written.
// With pop low the back end keeps issuing until 16 pixels are outstanding,
// then the 4-word front queue fills and full rises.
// ----------------------------------------------------------------------------
module cross_channel_color_correction #(
   parameter int CURVE_DEPTH   = 256,
   parameter int FRACTION_BITS = 14
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire logic                      req_command,
   input  wire ccc_pkg::pixel_type        req_in_red,
   input  wire ccc_pkg::pixel_type        req_in_green,
   input  wire ccc_pkg::pixel_type        req_in_blue,
   input  wire logic [ccc_pkg::SEL_W-1:0] req_table_select,
   input  wire ccc_pkg::pixel_type        req_table_index,
   input  wire ccc_pkg::value_type        req_table_value,
   output logic                           empty,
   input  wire logic                      pop,
   output ccc_pkg::pixel_type             rsp_out_red,
   output ccc_pkg::pixel_type             rsp_out_green,
   output ccc_pkg::pixel_type             rsp_out_blue
);
   import ccc_pkg::*;

   logic    mid_valid;
   logic    mid_pop;
   cmd_type mid_word;

   ccc_front #(
      .CURVE_DEPTH (CURVE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .command      (req_command),
      .in_red       (req_in_red),
      .in_green     (req_in_green),
      .in_blue      (req_in_blue),
      .table_select (req_table_select),
      .table_index  (req_table_index),
      .table_value  (req_table_value),
      .mid_valid    (mid_valid),
      .mid_word     (mid_word),
      .mid_pop      (mid_pop)
   );

   ccc_back #(
      .CURVE_DEPTH   (CURVE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_word  (mid_word),
      .mid_pop   (mid_pop),
      .empty     (empty),
      .pop       (pop),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue)
   );

endmodule
`default_nettype wire

// ----- dv/tb_cross_channel_color_correction.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cross_channel_color_correction
// Self-checking bench for the RGB curve-correction block. Curve entries are
// loaded by table-write words and pixels only use bytes whose curves are
// loaded. Each pixel response is compared with its directed step's value
// or a predictor in exact integer math. Push and pop both idle at random, and
// pop is held off for long stretches so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_cross_channel_color_correction;
   import ccc_pkg::*;

   localparam int FB           = 14;
   localparam int DEPTH        = 256;
   localparam int ITEMS        = 1400;
   localparam int N_STEPS      = 28;
   localparam int HOLD_CYCLES  = 200;
   localparam int HOLD_AT_A    = 100;
   localparam int HOLD_AT_B    = 500;
   localparam int DRAIN        = 32;
   localparam int unsigned LIMIT = 600_000;

   typedef enum logic [SEL_W-1:0] {
      CV_R, CV_G, CV_B, CV_GR, CV_BR, CV_RG, CV_BG, CV_RB, CV_GB
   } curve_type;

   localparam logic [SEL_W-1:0] SEL_VOID = SEL_LAST + 4'd1;
   localparam logic [SEL_W-1:0] SEL_TOP  = '1;
   localparam value_type VALUE_MAX = value_type'(18'h1FFFF);
   localparam value_type VALUE_MIN = value_type'(18'h20000);
   localparam value_type VALUE_ONE = value_type'(18'h04000);
   localparam chan_type CHAN_OF [NUM_CURVES] =
      '{CH_R, CH_G, CH_B, CH_G, CH_B, CH_R, CH_B, CH_R, CH_G};

   typedef struct packed {
      pixel_type red;
      pixel_type green;
      pixel_type blue;
   } rgb_type;

   typedef struct packed {
      cmd_type word;
      logic    typed;
      rgb_type want;
   } step_type;

   logic      clock            = 1'b0;
   logic      reset            = 1'b1;
   logic      push             = 1'b0;
   logic      pop              = 1'b0;
   logic      req_command      = CMD_PIXEL;
   pixel_type req_in_red       = '0;
   pixel_type req_in_green     = '0;
   pixel_type req_in_blue      = '0;
   logic [SEL_W-1:0] req_table_select = '0;
   pixel_type req_table_index  = '0;
   value_type req_table_value  = '0;
   logic      full;
   logic      empty;
   pixel_type rsp_out_red;
   pixel_type rsp_out_green;
   pixel_type rsp_out_blue;

   // predictor state
   value_type curve_mem [NUM_CURVES][DEPTH];
   bit        curve_set [NUM_CURVES][DEPTH];
   bit        byte_ready [NUM_CHANNELS][DEPTH];
   rgb_type   rgb_due [$];

   step_type    steps [N_STEPS];
   int          n_pixel   = 0;
   int          n_write   = 0;
   int          n_ignored = 0;
   int          n_checked = 0;
   int          errors    = 0;
   int unsigned cycles    = 0;

   cross_channel_color_correction u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_command      (req_command),
      .req_in_red       (req_in_red),
      .req_in_green     (req_in_green),
      .req_in_blue      (req_in_blue),
      .req_table_select (req_table_select),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // t = f*2^2F + (ca+cb)*(1-f)^2 in Q.3F, then round(255*t) with saturation
   function automatic pixel_type shade_channel(value_type f, value_type ca, value_type cb);
      longint d;
      longint t;
      d = (longint'(1) << FB) - longint'(f);
      t = longint'(f) * (longint'(1) << (2 * FB)) + (longint'(ca) + longint'(cb)) * d * d;
      if (t < 0) return '0;
      if (t >= (longint'(1) << (3 * FB))) return PIXEL_MAX;
      return pixel_type'((longint'(255) * t + (longint'(1) << (3 * FB - 1))) >>> (3 * FB));
   endfunction

   function automatic rgb_type correct_pixel(pixel_type r, pixel_type g, pixel_type b);
      rgb_type o;
      o.red   = shade_channel(curve_mem[CV_R][r], curve_mem[CV_GR][g], curve_mem[CV_BR][b]);
      o.green = shade_channel(curve_mem[CV_G][g], curve_mem[CV_RG][r], curve_mem[CV_BG][b]);
      o.blue  = shade_channel(curve_mem[CV_B][b], curve_mem[CV_RB][r], curve_mem[CV_GB][g]);
      return o;
   endfunction

   function automatic void store_entry(logic [SEL_W-1:0] sel, pixel_type idx, value_type val);
      chan_type ch;
      bit       ok;
      curve_mem[sel][idx] = val;
      curve_set[sel][idx] = 1'b1;
      ch = CHAN_OF[sel];
      ok = 1'b1;
      for (int k = 0; k < NUM_CURVES; k++)
         if (CHAN_OF[k] == ch && !curve_set[k][idx]) ok = 1'b0;
      byte_ready[ch][idx] = ok;
   endfunction

   function automatic int idle_len(inout int steady);
      int unsigned r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         steady = int'($urandom_range(20, 60));
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic value_type pick_value(bit primary);
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return value_type'(18'($urandom));
      if (r == 1) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return VALUE_ONE;
            default: return '0;
         endcase
      end
      if (primary) return value_type'(18'($urandom_range(0, 2 * (1 << FB))));
      return value_type'(18'(int'($urandom_range(0, 1 << FB)) - (1 << (FB - 1))));
   endfunction

   function automatic pixel_type pick_ready(chan_type ch);
      pixel_type b;
      do b = 8'($urandom_range(0, 255)); while (!byte_ready[ch][b]);
      return b;
   endfunction

   function automatic cmd_type noise_word();
      cmd_type w;
      w.is_write = CMD_PIXEL;
      w.sel      = 4'($urandom_range(0, 15));
      w.index    = 8'($urandom_range(0, 255));
      w.value    = value_type'(18'($urandom));
      w.red      = 8'($urandom_range(0, 255));
      w.green    = 8'($urandom_range(0, 255));
      w.blue     = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic step_type wr(logic [SEL_W-1:0] sel, pixel_type idx, value_type val);
      step_type s;
      s = '0;
      s.word.is_write = CMD_WRITE;
      s.word.sel      = sel;
      s.word.index    = idx;
      s.word.value    = val;
      s.word.red      = 8'hA5;
      s.word.green    = 8'h5A;
      s.word.blue     = 8'hC3;
      return s;
   endfunction

   function automatic step_type px(pixel_type r, pixel_type g, pixel_type b, logic typed,
                                   pixel_type er, pixel_type eg, pixel_type eb);
      step_type s;
      s.word.is_write = CMD_PIXEL;
      s.word.sel      = SEL_TOP;
      s.word.index    = 8'hFF;
      s.word.value    = VALUE_MIN;
      s.word.red      = r;
      s.word.green    = g;
      s.word.blue     = b;
      s.typed         = typed;
      s.want          = '{er, eg, eb};
      return s;
   endfunction

   int send_steady = 0;

   task automatic send(input cmd_type w, input logic typed, input rgb_type want);
      int gap;
      gap = idle_len(send_steady);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command      <= w.is_write;
      req_in_red       <= w.red;
      req_in_green     <= w.green;
      req_in_blue      <= w.blue;
      req_table_select <= w.sel;
      req_table_index  <= w.index;
      req_table_value  <= w.value;
      push             <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      if (w.is_write == CMD_WRITE) begin
         if (w.sel <= SEL_LAST) begin
            store_entry(w.sel, w.index, w.value);
            n_write++;
         end else begin
            n_ignored++;
         end
      end else begin
         rgb_due.push_back(typed ? want : correct_pixel(w.red, w.green, w.blue));
         n_pixel++;
      end
   endtask

   // result side: random pop gaps plus two long hold-offs
   initial begin
      int gap;
      int popped;
      int steady;
      popped = 0;
      steady = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_len(steady);
         if (popped == HOLD_AT_A || popped == HOLD_AT_B) gap = HOLD_CYCLES;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         popped++;
      end
   end

   always @(posedge clock) begin
      rgb_type want;
      if (!reset && pop && !empty) begin
         if (rgb_due.size() == 0) begin
            $error("response word with no pixel outstanding: %0d %0d %0d",
                   rsp_out_red, rsp_out_green, rsp_out_blue);
            errors++;
         end else begin
            want = rgb_due.pop_front();
            n_checked <= n_checked + 1;
            if (rsp_out_red !== want.red) begin
               $error("out_red: expected %0d, got %0d", want.red, rsp_out_red);
               errors++;
            end
            if (rsp_out_green !== want.green) begin
               $error("out_green: expected %0d, got %0d", want.green, rsp_out_green);
               errors++;
            end
            if (rsp_out_blue !== want.blue) begin
               $error("out_blue: expected %0d, got %0d", want.blue, rsp_out_blue);
               errors++;
            end
         end
      end
   end

   initial begin
      cmd_type     w;
      int unsigned kind;
      chan_type    ch;
      pixel_type   idx;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steps = '{
         wr(CV_R, 8'd0, '0), wr(CV_G, 8'd0, '0), wr(CV_B, 8'd0, '0),
         wr(CV_GR, 8'd0, '0), wr(CV_BR, 8'd0, '0), wr(CV_RG, 8'd0, '0),
         wr(CV_BG, 8'd0, '0), wr(CV_RB, 8'd0, '0), wr(CV_GB, 8'd0, '0),
         px(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0),
         wr(CV_R, 8'd255, VALUE_ONE), wr(CV_G, 8'd255, VALUE_ONE),
         wr(CV_B, 8'd255, VALUE_ONE),
         wr(CV_GR, 8'd255, VALUE_MAX), wr(CV_BR, 8'd255, VALUE_MIN),
         wr(CV_RG, 8'd255, VALUE_MAX), wr(CV_BG, 8'd255, VALUE_MIN),
         wr(CV_RB, 8'd255, VALUE_MAX), wr(CV_GB, 8'd255, VALUE_MIN),
         // primary at 1.0 kills the cross term
         px(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255),
         px(8'd0, 8'd255, 8'd0, 1'b1, 8'd255, 8'd255, 8'd0),
         px(8'd0, 8'd0, 8'd255, 1'b1, 8'd0, 8'd0, 8'd255),
         px(8'd255, 8'd0, 8'd0, 1'b1, 8'd255, 8'd255, 8'd255),
         // out-of-range selects must not touch any curve
         wr(SEL_VOID, 8'd0, VALUE_MAX), wr(SEL_TOP, 8'd0, VALUE_MIN),
         px(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0),
         wr(CV_R, 8'd0, value_type'(18'h02000)),
         px(8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0)
      };
      foreach (steps[i]) send(steps[i].word, steps[i].typed, steps[i].want);

      while (n_pixel + n_write < ITEMS) begin
         kind = $urandom_range(0, 99);
         w = noise_word();
         if (kind < 15) begin
            // load all three curves addressed by one channel byte
            ch  = chan_type'($urandom_range(0, 2));
            idx = 8'($urandom_range(0, 255));
            for (int k = 0; k < NUM_CURVES; k++) begin
               if (CHAN_OF[k] == ch) begin
                  w = noise_word();
                  w.is_write = CMD_WRITE;
                  w.sel      = 4'(k);
                  w.index    = idx;
                  w.value    = pick_value(k <= CV_B);
                  send(w, 1'b0, '0);
               end
            end
         end else if (kind < 25) begin
            w.is_write = CMD_WRITE;
            w.sel      = 4'($urandom_range(0, SEL_LAST));
            w.value    = pick_value(w.sel <= CV_B);
            send(w, 1'b0, '0);
         end else if (kind < 28) begin
            w.is_write = CMD_WRITE;
            w.sel      = 4'($urandom_range(SEL_VOID, SEL_TOP));
            send(w, 1'b0, '0);
         end else begin
            w.red   = pick_ready(CH_R);
            w.green = pick_ready(CH_G);
            w.blue  = pick_ready(CH_B);
            send(w, 1'b0, '0);
         end
      end
      push <= 1'b0;

      while (rgb_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("sent %0d pixels, %0d curve writes, %0d writes to unused selects",
               n_pixel, n_write, n_ignored);
      $display("compared %0d corrected pixels, %0d mismatches", n_checked, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
